### rtl/eld_pkg.sv
// Shared types, codes and the hex digit decoder of the escaped line decoder.
`timescale 1ns / 1ps

package eld_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_ERROR  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_KEPT    = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_HASH   = 8'h23;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### rtl/eld_decode.sv
// Escape decoder: mode and entry state with the per-item decision logic.
`timescale 1ns / 1ps

module eld_decode import eld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  mode_t      mode, mode_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       entry_empty, entry_empty_next;
  logic       first_is_hash, first_is_hash_next;
  hex_t       hx;

  assign hx = hex_digit(item.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      high_nibble   <= 4'd0;
      entry_empty   <= 1'b1;
      first_is_hash <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      high_nibble   <= high_nibble_next;
      entry_empty   <= entry_empty_next;
      first_is_hash <= first_is_hash_next;
    end
  end

  // next state
  always_comb begin
    mode_next = mode;
    if (item.eof) begin
      mode_next = MODE_NORMAL;
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          if (item.data == CH_BSLASH) mode_next = MODE_ESC;
        end
        MODE_ESC: begin
          if (item.data == CH_N || item.data == CH_T || item.data == CH_BSLASH ||
              item.data == CH_R) begin
            mode_next = MODE_NORMAL;
          end else if (item.data == CH_X) begin
            mode_next = MODE_HEX1;
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        MODE_HEX1: mode_next = hx.ok ? MODE_HEX2 : MODE_ERROR;
        MODE_HEX2: mode_next = hx.ok ? MODE_NORMAL : MODE_ERROR;
        default:   mode_next = MODE_ERROR;
      endcase
    end
  end

  // result and entry tracking
  always_comb begin
    logic       emit;
    logic [7:0] b;
    emit               = 1'b0;
    b                  = item.data;
    res                = '0;
    res.kind           = KIND_BYTE;
    high_nibble_next   = high_nibble;
    entry_empty_next   = entry_empty;
    first_is_hash_next = first_is_hash;
    if (mode != MODE_NORMAL && mode != MODE_ESC && mode != MODE_HEX1 &&
        mode != MODE_HEX2) begin
      if (item.eof) begin
        high_nibble_next   = 4'd0;
        entry_empty_next   = 1'b1;
        first_is_hash_next = 1'b0;
      end
    end else if (item.eof) begin
      entry_empty_next   = 1'b1;
      first_is_hash_next = 1'b0;
      res.valid          = 1'b1;
      if (mode == MODE_NORMAL) begin
        res.kind = (entry_empty || first_is_hash) ? KIND_DROPPED : KIND_KEPT;
      end else begin
        high_nibble_next = 4'd0;
        res.kind         = KIND_ERROR;
      end
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          if (item.data == CH_LF) begin
            res.valid          = 1'b1;
            res.kind           = (entry_empty || first_is_hash) ? KIND_DROPPED : KIND_KEPT;
            entry_empty_next   = 1'b1;
            first_is_hash_next = 1'b0;
          end else if (item.data != CH_BSLASH) begin
            emit = 1'b1;
          end
        end
        MODE_ESC: begin
          if (item.data == CH_N) begin
            emit = 1'b1;
            b    = CH_LF;
          end else if (item.data == CH_T) begin
            emit = 1'b1;
            b    = CH_TAB;
          end else if (item.data == CH_BSLASH) begin
            emit = 1'b1;
          end else if (item.data != CH_R && item.data != CH_X) begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
          end
        end
        MODE_HEX1: begin
          if (hx.ok) begin
            high_nibble_next = hx.value;
          end else begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
          end
        end
        default: begin
          if (hx.ok) begin
            emit = 1'b1;
            b    = {high_nibble, hx.value};
          end else begin
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
          end
        end
      endcase
      if (emit) begin
        res.valid = 1'b1;
        res.kind  = KIND_BYTE;
        res.data  = b;
        if (entry_empty) begin
          entry_empty_next   = 1'b0;
          first_is_hash_next = (b == CH_HASH);
        end
      end
    end
  end

endmodule

### rtl/escaped_line_decoder_top.sv
// Top level of the escaped line decoder: input register, decoder, result register.
// An accepted item is held in the input register, decoded combinationally, and its result is
// written to the result register. Throughput: one item per cycle while the result register
// is not stalled by m_tready. Items that cause no result leave nothing.
// Reset: synchronous, active high; clears both valid flags and returns the decoder to
// normal mode with an empty entry.
`timescale 1ns / 1ps

module escaped_line_decoder_top import eld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_file
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser    // [1:0] kind
);

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  logic    step;
  result_t res;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.data <= s_tdata;
      in_item.eof  <= s_tlast;
    end
  end

  eld_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= res.data;
      m_tuser <= res.kind;
    end
  end

endmodule

### rtl/eld_checker.sv
// Port-level checks of the escaped line decoder and their binding to the top level.
`timescale 1ns / 1ps

module eld_checker import eld_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BYTE |-> m_tdata == 8'd0)
    else $error("entry end or error item carries data");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with result register empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind escaped_line_decoder_top eld_checker u_eld_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
